@@ design/grd_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and register codes of the gyro rotary dimmer
package grd_pkg;

	localparam logic [15:0] FULL_SCALE = 16'd50000;
	localparam int unsigned DIV_RAW = FULL_SCALE / 100;
	localparam int unsigned DIV = (DIV_RAW == 0) ? 1 : DIV_RAW;

	localparam int unsigned RECIP_SH = 32;
	localparam longint unsigned RECIP_L = ((64'd1 << RECIP_SH) + DIV - 1) / DIV;
	localparam logic [32:0] RECIP = 33'(RECIP_L);

	localparam logic [6:0] BRIGHT_MIN = 7'd1;
	localparam logic [6:0] BRIGHT_MAX = 7'd100;

	localparam logic [14:0] DEADBAND_RESET = 15'd200;
	localparam logic [15:0] IDLE_LIMIT_RESET = 16'd30;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEADBAND   = 2'd0,
		REG_IDLE_LIMIT = 2'd1
	} reg_idx_t;

	typedef struct packed {
		logic [14:0] deadband_threshold;
		logic [15:0] idle_limit;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		logic        press;
		logic        inactive;
		logic [15:0] level;
	} lvl_stage_t;

endpackage

@@ design/grd_channels.sv @@
`timescale 1ns / 1ps
// channel interfaces for samples, results and register writes
interface grd_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] rate_z;
	logic               button_press;

	modport source (output valid, output rate_z, output button_press, input ready);
	modport sink (input valid, input rate_z, input button_press, output ready);
endinterface

interface grd_result_if;
	logic       valid;
	logic       ready;
	logic [6:0] brightness;
	logic       brightness_changed;
	logic       toggle_request;
	logic       inactive;

	modport source (output valid, output brightness, output brightness_changed,
		output toggle_request, output inactive, input ready);
	modport sink (input valid, input brightness, input brightness_changed,
		input toggle_request, input inactive, output ready);
endinterface

interface grd_cfg_if;
	import grd_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/gyro_rotary_dimmer_top.sv @@
`timescale 1ns / 1ps
// top level of the gyro rotary dimmer
// usage:
//   sample carries one signed z-rate reading and a button flag per request;
//   result returns one request per sample: brightness percent, a change
//   flag against the last result, the toggle request and the inactive flag
//   cfg writes register 0 (deadband threshold) or 1 (idle limit); other
//   indexes are dropped, and writes are always taken
// timing:
//   a taken sample passes the input register, the level/idle register and
//   the result register in that order and is offered on result from there
//   one sample per cycle sustained while result is taken; the level and
//   idle updates are combinational ahead of the level/idle register and
//   the brightness multiply sits in the last stage
// reset:
//   deadband 200, idle limit 30, level 0, last brightness 1, all stages empty
// stalls:
//   while result waits the earlier stages keep filling; sample.ready drops
//   only once all three registers hold requests
module gyro_rotary_dimmer_top (
	input  logic clk,
	input  logic arst_n,
	grd_sample_if.sink   sample,
	grd_result_if.source result,
	grd_cfg_if.sink      cfg
);
	import grd_pkg::*;

	cfg_t       cfg_regs;
	lvl_stage_t lvl;
	logic       take;

	grd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_ready (cfg.ready),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	grd_level_stage u_level (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (sample.valid),
		.in_ready     (sample.ready),
		.rate_z       (sample.rate_z),
		.button_press (sample.button_press),
		.cfg          (cfg_regs),
		.take         (take),
		.lvl          (lvl)
	);

	grd_bright_stage u_bright (
		.clk                (clk),
		.arst_n             (arst_n),
		.lvl                (lvl),
		.take               (take),
		.out_valid          (result.valid),
		.out_ready          (result.ready),
		.brightness         (result.brightness),
		.brightness_changed (result.brightness_changed),
		.toggle_request     (result.toggle_request),
		.inactive           (result.inactive)
	);

endmodule

@@ design/grd_cfg_regs.sv @@
`timescale 1ns / 1ps
// configuration registers: deadband threshold and idle limit
module grd_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_valid,
	output logic                           wr_ready,
	input  logic [grd_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [grd_pkg::CFG_DATA_W-1:0] wr_data,
	output grd_pkg::cfg_t                  cfg
);
	import grd_pkg::*;

	logic [14:0] deadband_q;
	logic [15:0] idle_limit_q;

	assign wr_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q   <= DEADBAND_RESET;
			idle_limit_q <= IDLE_LIMIT_RESET;
		end else if (wr_valid) begin
			case (wr_index)
				REG_DEADBAND: begin
					deadband_q <= wr_data[14:0];
				end
				REG_IDLE_LIMIT: begin
					idle_limit_q <= wr_data[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.deadband_threshold = deadband_q;
	assign cfg.idle_limit         = idle_limit_q;

endmodule

@@ design/grd_level_stage.sv @@
`timescale 1ns / 1ps
// sample register, deadband, dimmer level accumulation and idle counting
module grd_level_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [15:0]  rate_z,
	input  logic                button_press,
	input  grd_pkg::cfg_t       cfg,
	input  logic                take,
	output grd_pkg::lvl_stage_t lvl
);
	import grd_pkg::*;

	logic               valid_s1;
	logic signed [15:0] rate_s1;
	logic               press_s1;

	logic               valid_s2;
	logic               press_s2;
	logic               inactive_s2;
	logic [15:0]        level_q;
	logic [15:0]        idle_q;

	logic               en_s1;
	logic               en_s2;
	logic signed [16:0] rate_ext;
	logic [16:0]        mag;
	logic               pass;
	logic               activity;
	logic signed [17:0] sum;
	logic [15:0]        level_next;
	logic [15:0]        idle_next;

	assign en_s2    = !valid_s2 || take;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	// deadband on the rate magnitude
	assign rate_ext = {rate_s1[15], rate_s1};
	assign mag      = rate_ext[16] ? 17'(-rate_ext) : 17'(rate_ext);
	assign pass     = mag >= {2'b00, cfg.deadband_threshold};
	assign activity = pass || press_s1;

	// a right turn (negative rate) raises the level
	assign sum = pass ? ($signed({2'b00, level_q}) - $signed({{2{rate_s1[15]}}, rate_s1}))
		: $signed({2'b00, level_q});

	always_comb begin
		if (sum[17]) begin
			level_next = '0;
		end else if (sum >= $signed({2'b00, FULL_SCALE})) begin
			level_next = FULL_SCALE;
		end else begin
			level_next = sum[15:0];
		end
	end

	always_comb begin
		if (activity) begin
			idle_next = '0;
		end else if (idle_q <= cfg.idle_limit && idle_q != 16'hFFFF) begin
			idle_next = idle_q + 16'd1;
		end else begin
			idle_next = idle_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			level_q  <= '0;
			idle_q   <= '0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (valid_s1 && en_s2) begin
				level_q <= level_next;
				idle_q  <= idle_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && en_s1) begin
			rate_s1  <= rate_z;
			press_s1 <= button_press;
		end
		if (valid_s1 && en_s2) begin
			press_s2    <= press_s1;
			inactive_s2 <= idle_next > cfg.idle_limit;
		end
	end

	assign lvl.valid    = valid_s2;
	assign lvl.press    = press_s2;
	assign lvl.inactive = inactive_s2;
	assign lvl.level    = level_q;

endmodule

@@ design/grd_bright_stage.sv @@
`timescale 1ns / 1ps
// brightness percent by reciprocal multiply, change flag and result register
module grd_bright_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  grd_pkg::lvl_stage_t lvl,
	output logic                take,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [6:0]          brightness,
	output logic                brightness_changed,
	output logic                toggle_request,
	output logic                inactive
);
	import grd_pkg::*;

	logic        valid_s3;
	logic [6:0]  bright_s3;
	logic        changed_s3;
	logic        toggle_s3;
	logic        inactive_s3;
	logic [6:0]  reported_q;

	logic [48:0] prod;
	logic [16:0] quot;
	logic [6:0]  bright;

	assign take = !valid_s3 || out_ready;

	assign prod = 49'(lvl.level) * 49'(RECIP);
	assign quot = prod[48:32];

	always_comb begin
		if (quot == '0) begin
			bright = BRIGHT_MIN;
		end else if (quot > 17'(BRIGHT_MAX)) begin
			bright = BRIGHT_MAX;
		end else begin
			bright = quot[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3   <= 1'b0;
			reported_q <= BRIGHT_MIN;
		end else begin
			if (take) begin
				valid_s3 <= lvl.valid;
			end
			if (lvl.valid && take) begin
				reported_q <= bright;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (lvl.valid && take) begin
			bright_s3   <= bright;
			changed_s3  <= bright != reported_q;
			toggle_s3   <= lvl.press;
			inactive_s3 <= lvl.inactive;
		end
	end

	assign out_valid          = valid_s3;
	assign brightness         = bright_s3;
	assign brightness_changed = changed_s3;
	assign toggle_request     = toggle_s3;
	assign inactive           = inactive_s3;

endmodule

@@ design/grd_checker.sv @@
`timescale 1ns / 1ps
// port checker for the gyro rotary dimmer and its bind
module grd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] brightness,
	input logic       brightness_changed,
	input logic       toggle_request,
	input logic       inactive
);
	import grd_pkg::*;

	// empty result register means the sample side is open
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("sample not ready with empty result register");

	a_bright_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (brightness >= BRIGHT_MIN && brightness <= BRIGHT_MAX))
		else $error("brightness out of range");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(brightness) && $stable(brightness_changed)
			&& $stable(toggle_request) && $stable(inactive))
		else $error("result payload changed while stalled");

endmodule

bind gyro_rotary_dimmer_top grd_checker u_grd_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_ready           (sample.ready),
	.out_valid          (result.valid),
	.out_ready          (result.ready),
	.brightness         (result.brightness),
	.brightness_changed (result.brightness_changed),
	.toggle_request     (result.toggle_request),
	.inactive           (result.inactive)
);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the gyro rotary dimmer: directed table, idle-limit runs, then random phases
module testbench;
	import grd_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int HOLD_CYCLES = 120;
	localparam int SCALE = int'(FULL_SCALE);
	localparam int PCT_DIV = (SCALE / 100 == 0) ? 1 : SCALE / 100;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef struct packed {
		logic [6:0] brightness;
		logic       changed;
		logic       toggle;
		logic       inactive;
	} dim_result_t;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic signed [15:0]   rate;
		logic                 press;
		logic [CFG_IDX_W-1:0] idx;
		logic [15:0]          data;
		logic                 typed;
		dim_result_t          want;
	} stim_row_t;

	typedef enum logic [1:0] {TURN_IDLE, TURN_UP, TURN_DOWN, TURN_NOISE} turn_kind_t;

	localparam stim_row_t DIR_TABLE [26] = '{
		'{ROW_SAMPLE, 16'sd0, 1'b0, REG_DEADBAND, 16'd0, 1'b1, '{7'd1, 1'b0, 1'b0, 1'b0}},
		'{ROW_SAMPLE, 16'sd199, 1'b0, REG_DEADBAND, 16'd0, 1'b1, '{7'd1, 1'b0, 1'b0, 1'b0}},
		'{ROW_SAMPLE, -16'sd200, 1'b0, REG_DEADBAND, 16'd0, 1'b1, '{7'd1, 1'b0, 1'b0, 1'b0}},
		'{ROW_SAMPLE, 16'sd200, 1'b0, REG_DEADBAND, 16'd0, 1'b1, '{7'd1, 1'b0, 1'b0, 1'b0}},
		'{ROW_SAMPLE, 16'sh8000, 1'b0, REG_DEADBAND, 16'd0, 1'b1, '{7'd65, 1'b1, 1'b0, 1'b0}},
		'{ROW_SAMPLE, 16'sh8000, 1'b0, REG_DEADBAND, 16'd0, 1'b1, '{7'd100, 1'b1, 1'b0, 1'b0}},
		'{ROW_SAMPLE, 16'sh8000, 1'b0, REG_DEADBAND, 16'd0, 1'b1, '{7'd100, 1'b0, 1'b0, 1'b0}},
		'{ROW_SAMPLE, 16'sd32767, 1'b0, REG_DEADBAND, 16'd0, 1'b0, '0},
		'{ROW_SAMPLE, 16'sd32767, 1'b0, REG_DEADBAND, 16'd0, 1'b1, '{7'd1, 1'b1, 1'b0, 1'b0}},
		'{ROW_SAMPLE, 16'sd32767, 1'b1, REG_DEADBAND, 16'd0, 1'b1, '{7'd1, 1'b0, 1'b1, 1'b0}},
		'{ROW_SAMPLE, 16'sd0, 1'b1, REG_DEADBAND, 16'd0, 1'b1, '{7'd1, 1'b0, 1'b1, 1'b0}},
		'{ROW_WRITE, 16'sd0, 1'b0, REG_DEADBAND, 16'd0, 1'b0, '0},
		'{ROW_SAMPLE, 16'sd0, 1'b0, REG_DEADBAND, 16'd0, 1'b1, '{7'd1, 1'b0, 1'b0, 1'b0}},
		'{ROW_WRITE, 16'sd0, 1'b0, REG_IDLE_LIMIT, 16'd1, 1'b0, '0},
		'{ROW_WRITE, 16'sd0, 1'b0, REG_DEADBAND, 16'hFFFF, 1'b0, '0},
		'{ROW_SAMPLE, 16'sd100, 1'b0, REG_DEADBAND, 16'd0, 1'b1, '{7'd1, 1'b0, 1'b0, 1'b0}},
		'{ROW_SAMPLE, -16'sd32767, 1'b0, REG_DEADBAND, 16'd0, 1'b0, '0},
		'{ROW_SAMPLE, 16'sd0, 1'b0, REG_DEADBAND, 16'd0, 1'b0, '0},
		'{ROW_SAMPLE, 16'sd0, 1'b0, REG_DEADBAND, 16'd0, 1'b0, '0},
		'{ROW_SAMPLE, 16'sd0, 1'b0, REG_DEADBAND, 16'd0, 1'b0, '0},
		'{ROW_WRITE, 16'sd0, 1'b0, REG_SPARE_2, 16'd0, 1'b0, '0},
		'{ROW_WRITE, 16'sd0, 1'b0, REG_SPARE_3, 16'd5, 1'b0, '0},
		'{ROW_SAMPLE, 16'sd0, 1'b0, REG_DEADBAND, 16'd0, 1'b0, '0},
		'{ROW_SAMPLE, 16'sh8000, 1'b0, REG_DEADBAND, 16'd0, 1'b0, '0},
		'{ROW_WRITE, 16'sd0, 1'b0, REG_IDLE_LIMIT, 16'd65534, 1'b0, '0},
		'{ROW_WRITE, 16'sd0, 1'b0, REG_DEADBAND, 16'd200, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;

	grd_sample_if sample_ch ();
	grd_result_if result_ch ();
	grd_cfg_if    cfg_ch ();

	gyro_rotary_dimmer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// mirror of the block state and registers
	int          level_q;
	int unsigned shown_q;
	int unsigned idle_q;
	logic [14:0] thr_q;
	logic [15:0] limit_q;

	dim_result_t due_reports [$];
	int          mismatches = 0;
	int          cycle_count = 0;
	bit          quiet = 1'b0;
	bit          hold_req = 1'b0;
	turn_kind_t  turn_kind = TURN_IDLE;
	int          turn_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic dim_result_t dim_step(input logic signed [15:0] rate, input logic press);
		int          lvl;
		int          mag;
		int unsigned pct;
		logic        act;
		dim_result_t r;
		mag = (rate < 0) ? -int'(rate) : int'(rate);
		act = press;
		lvl = level_q;
		if (mag >= int'(thr_q)) begin
			lvl = lvl - int'(rate);
			act = 1'b1;
		end
		if (lvl > SCALE)
			lvl = SCALE;
		else if (lvl < 0)
			lvl = 0;
		level_q = lvl;
		pct = lvl / PCT_DIV;
		if (pct < 1)
			pct = 1;
		if (pct > 100)
			pct = 100;
		r.brightness = pct[6:0];
		r.changed = (pct != shown_q);
		shown_q = pct;
		if (act)
			idle_q = 0;
		else if (idle_q <= int'(limit_q) && idle_q < 65535)
			idle_q++;
		r.toggle = press;
		r.inactive = (idle_q > int'(limit_q));
		return r;
	endfunction

	task automatic next_sample(output logic signed [15:0] rate, output logic press);
		int thr;
		int mag;
		int top;
		thr = int'(thr_q);
		if (turn_left == 0) begin
			turn_kind = turn_kind_t'($urandom_range(3));
			turn_left = (turn_kind == TURN_IDLE) ? $urandom_range(10, 80) : $urandom_range(5, 50);
		end
		turn_left--;
		press = ($urandom_range(99) < ((turn_kind == TURN_IDLE) ? 2 : 8));
		case (turn_kind)
			TURN_IDLE: begin
				mag = (thr == 0) ? 0 : $urandom_range(0, thr - 1);
				rate = $urandom_range(1) ? 16'(-mag) : 16'(mag);
			end
			TURN_UP, TURN_DOWN: begin
				top = (thr + 4000 > 32767) ? 32767 : thr + 4000;
				mag = ($urandom_range(3) == 0) ? $urandom_range(thr, 32767) : $urandom_range(thr, top);
				rate = (turn_kind == TURN_UP) ? 16'(-mag) : 16'(mag);
			end
			default: begin
				rate = 16'($urandom);
			end
		endcase
	endtask

	// entered at a falling edge, left at the falling edge after the request is taken
	task automatic send_sample(input logic signed [15:0] rate, input logic press,
		input logic typed, input dim_result_t want);
		dim_result_t calc;
		while (!quiet && $urandom_range(99) < 27) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.rate_z <= rate;
		sample_ch.button_press <= press;
		do @(posedge clk); while (!sample_ch.ready);
		calc = dim_step(rate, press);
		due_reports.push_back(typed ? want : calc);
		@(negedge clk);
	endtask

	task automatic settle();
		sample_ch.valid <= 1'b0;
		do @(negedge clk); while (due_reports.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == REG_DEADBAND)
			thr_q = val[14:0];
		else if (idx == REG_IDLE_LIMIT)
			limit_q = val;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic idle_run(input int count);
		int v;
		for (int n = 0; n < count; n++) begin
			v = $urandom_range(0, 398);
			send_sample(16'(v - 199), 1'b0, 1'b0, '0);
		end
	endtask

	// receiver side: random stalls outside the quiet phase, a long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else if (quiet) begin
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= 27);
			end
		end
	end

	always @(posedge clk) begin
		dim_result_t want;
		dim_result_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = '{result_ch.brightness, result_ch.brightness_changed,
				result_ch.toggle_request, result_ch.inactive};
			if (due_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: brightness %0d changed %0b toggle %0b inactive %0b",
						got.brightness, got.changed, got.toggle, got.inactive);
			end else begin
				want = due_reports.pop_front();
				if (got.brightness !== want.brightness || got.changed !== want.changed ||
					got.toggle !== want.toggle || got.inactive !== want.inactive) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result differs: want %0d/%0b/%0b/%0b got %0d/%0b/%0b/%0b",
							want.brightness, want.changed, want.toggle, want.inactive,
							got.brightness, got.changed, got.toggle, got.inactive);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("gyro_rotary_dimmer_top: mismatch");
			$finish;
		end
	end

	initial begin
		logic signed [15:0] r;
		logic               p;
		logic [15:0]        thr_w;
		logic [15:0]        lim_w;
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.rate_z = '0;
		sample_ch.button_press = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		level_q = 0;
		shown_q = 1;
		idle_q = 0;
		thr_q = DEADBAND_RESET;
		limit_q = IDLE_LIMIT_RESET;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (DIR_TABLE[i]) begin
			if (DIR_TABLE[i].kind == ROW_WRITE) begin
				settle();
				write_reg(DIR_TABLE[i].idx, DIR_TABLE[i].data);
			end else begin
				send_sample(DIR_TABLE[i].rate, DIR_TABLE[i].press, DIR_TABLE[i].typed,
					DIR_TABLE[i].want);
			end
		end

		// idle count runs up, then limit raised to the top and lowered under the count
		idle_run(40);
		settle();
		write_reg(REG_IDLE_LIMIT, 16'd65535);
		idle_run(10);
		settle();
		write_reg(REG_IDLE_LIMIT, 16'd1);
		idle_run(10);

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			case (ph)
				0: begin
					thr_w = 16'd0;
					lim_w = 16'd1;
				end
				1: begin
					thr_w = 16'h7FFF;
					lim_w = 16'd65534;
				end
				default: begin
					thr_w = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
					lim_w = ($urandom_range(3) == 0) ? 16'($urandom_range(1, 65535)) :
						16'($urandom_range(1, 60));
				end
			endcase
			write_reg(REG_DEADBAND, thr_w);
			write_reg(REG_IDLE_LIMIT, lim_w);
			write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, 16'($urandom));
			quiet = (ph == 3);
			for (int n = 0; n < 155; n++) begin
				if (ph == 4 && n == 40)
					hold_req = 1'b1;
				if (ph == 5 && n == 85)
					settle();
				next_sample(r, p);
				send_sample(r, p, 1'b0, '0);
			end
		end

		settle();
		quiet = 1'b0;
		repeat (12) @(negedge clk);
		if (mismatches == 0 && due_reports.size() == 0)
			$display("gyro_rotary_dimmer_top: match");
		else
			$display("gyro_rotary_dimmer_top: mismatch");
		$finish;
	end
endmodule
